### rtl/core/bptl_pkg.sv
// ----------------------------------------------------------------------------
// bptl_pkg
// Shared types and constants of the bilinear property table lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package bptl_pkg;

  // number formats
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int IDX_W_MAX = 10;
  localparam int POS_W     = IDX_W_MAX + FRAC_W;
  localparam int SIZE_W    = 7;
  localparam int NUM_TABLES = 6;
  localparam int TBL_W     = 3;

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_ORIGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_INV     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_ROWS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_INV    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COLS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_EN    = 3'd6;

  // commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // quantities
  localparam logic [3:0] QTY_CP          = 4'd0;
  localparam logic [3:0] QTY_DENSITY     = 4'd1;
  localparam logic [3:0] QTY_EXPANSIVITY = 4'd2;
  localparam logic [3:0] QTY_VP          = 4'd3;
  localparam logic [3:0] QTY_VS          = 4'd4;
  localparam logic [3:0] QTY_ENTHALPY    = 4'd5;
  localparam logic [3:0] QTY_DHDT        = 4'd6;
  localparam logic [3:0] QTY_DHDP        = 4'd7;
  localparam logic [3:0] QTY_DRHODP      = 4'd8;

  typedef struct packed {
    logic signed [DATA_W-1:0] temp_origin;
    logic        [DATA_W-1:0] temp_inv;
    logic        [SIZE_W-1:0] temp_rows;
    logic signed [DATA_W-1:0] press_origin;
    logic        [DATA_W-1:0] press_inv;
    logic        [SIZE_W-1:0] press_cols;
    logic                     interp_en;
  } cfg_t;

  typedef struct packed {
    logic                     command;
    logic        [3:0]        quantity;
    logic        [5:0]        write_row;
    logic        [5:0]        write_col;
    logic signed [DATA_W-1:0] write_value;
  } item_t;

  // classified item: positions of the first and second sample
  typedef struct packed {
    item_t            item;
    logic [POS_W-1:0] t1;
    logic [POS_W-1:0] p1;
    logic [POS_W-1:0] t2;
    logic [POS_W-1:0] p2;
  } qentry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

`default_nettype wire

### rtl/core/bptl_if.sv
// ----------------------------------------------------------------------------
// bptl_in_if / bptl_out_if
// Valid/ready channels of the lookup core: items in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bptl_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [3:0]  quantity;
  logic signed [31:0] temperature;
  logic signed [31:0] pressure;
  logic [5:0]  write_row;
  logic [5:0]  write_col;
  logic signed [31:0] write_value;

  modport source (output valid, command, quantity, temperature, pressure,
                  write_row, write_col, write_value, input ready);
  modport sink   (input valid, command, quantity, temperature, pressure,
                  write_row, write_col, write_value, output ready);
endinterface

interface bptl_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink   (input valid, result_value, output ready);
endinterface

`default_nettype wire

### rtl/core/bptl_front.sv
// ----------------------------------------------------------------------------
// bptl_front
// Accepts items, maps coordinates to clamped Q10.16 grid positions and
// pushes classified items into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bptl_front #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  bptl_in_if.sink                in_ch,
  input  bptl_pkg::cfg_t         cfg,
  input  bptl_pkg::qstat_t       qstat,
  output logic                   push,
  output bptl_pkg::qentry_t      push_data
);

  localparam int RAW_W = 50;

  function automatic logic [bptl_pkg::POS_W-1:0] clamp_pos(
    input logic signed [RAW_W-1:0] raw, input logic [10:0] size);
    logic signed [RAW_W-1:0] lim;
    lim = $signed({23'b0, size - 11'd2, 16'b0});
    if (raw < 0) return '0;
    else if (raw > lim) return lim[bptl_pkg::POS_W-1:0];
    else return raw[bptl_pkg::POS_W-1:0];
  endfunction

  function automatic logic [10:0] eff_size(input logic [bptl_pkg::SIZE_W-1:0] r,
                                           input logic [10:0] maxv);
    logic [10:0] rz;
    rz = {4'b0, r};
    if (rz < 11'd2) return 11'd2;
    else if (rz > maxv) return maxv;
    else return rz;
  endfunction

  logic adv;

  // stage 1: item and coordinate offsets
  logic                s1_valid_r;
  bptl_pkg::item_t     s1_item_r;
  logic                s1_tneg_r, s1_pneg_r;
  logic [31:0]         s1_tmag_r, s1_pmag_r;
  logic signed [32:0]  dt, dp, dt_n, dp_n;

  // stage 2: scaled offsets
  logic                s2_valid_r;
  bptl_pkg::item_t     s2_item_r;
  logic                s2_tneg_r, s2_pneg_r;
  logic [63:0]         s2_tprod_r, s2_pprod_r;

  // stage 3 (comb): raw and clamped positions
  logic [64:0]            t_up, p_up;
  logic signed [RAW_W-1:0] t_raw, p_raw;
  logic [10:0]            rows_eff, cols_eff;
  logic [bptl_pkg::POS_W-1:0] tp, pp, tp_s, pp_s;

  assign adv         = !(s2_valid_r && qstat.full);
  assign in_ch.ready = adv;

  assign dt   = {in_ch.temperature[31], in_ch.temperature}
              - {cfg.temp_origin[31], cfg.temp_origin};
  assign dp   = {in_ch.pressure[31], in_ch.pressure}
              - {cfg.press_origin[31], cfg.press_origin};
  assign dt_n = -dt;
  assign dp_n = -dp;

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
    end
    if (adv) begin
      s1_item_r  <= '{command: in_ch.command, quantity: in_ch.quantity,
                      write_row: in_ch.write_row, write_col: in_ch.write_col,
                      write_value: in_ch.write_value};
      s1_tneg_r  <= dt[32];
      s1_pneg_r  <= dp[32];
      s1_tmag_r  <= dt[32] ? dt_n[31:0] : dt[31:0];
      s1_pmag_r  <= dp[32] ? dp_n[31:0] : dp[31:0];
      s2_item_r  <= s1_item_r;
      s2_tneg_r  <= s1_tneg_r;
      s2_pneg_r  <= s1_pneg_r;
      s2_tprod_r <= {32'b0, s1_tmag_r} * {32'b0, cfg.temp_inv};
      s2_pprod_r <= {32'b0, s1_pmag_r} * {32'b0, cfg.press_inv};
    end
  end

  // floor of the scaled offset, then clamp to the cell range
  always_comb begin
    t_up  = {1'b0, s2_tprod_r} + 65'h0FFFF;
    p_up  = {1'b0, s2_pprod_r} + 65'h0FFFF;
    t_raw = s2_tneg_r ? -$signed({1'b0, t_up[64:16]}) : $signed({2'b0, s2_tprod_r[63:16]});
    p_raw = s2_pneg_r ? -$signed({1'b0, p_up[64:16]}) : $signed({2'b0, s2_pprod_r[63:16]});
    rows_eff = eff_size(cfg.temp_rows, 11'(MAX_ROWS));
    cols_eff = eff_size(cfg.press_cols, 11'(MAX_COLS));
    tp   = clamp_pos(t_raw, rows_eff);
    pp   = clamp_pos(p_raw, cols_eff);
    tp_s = clamp_pos(t_raw + 50'sd65536, rows_eff);
    pp_s = clamp_pos(p_raw + 50'sd65536, cols_eff);
  end

  // queue push
  assign push           = s2_valid_r && !qstat.full;
  assign push_data.item = s2_item_r;
  assign push_data.t1   = tp;
  assign push_data.p1   = pp;
  assign push_data.t2   = (s2_item_r.quantity == bptl_pkg::QTY_DHDT) ? tp_s : tp;
  assign push_data.p2   = (s2_item_r.quantity == bptl_pkg::QTY_DHDT) ? pp : pp_s;

endmodule

`default_nettype wire

### rtl/core/bptl_queue.sv
// ----------------------------------------------------------------------------
// bptl_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module bptl_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  bptl_pkg::qentry_t      push_data,
  input  wire                    pop,
  output bptl_pkg::qentry_t      head,
  output bptl_pkg::qstat_t       qstat
);

  localparam int PTR_W = $clog2(bptl_pkg::QUEUE_DEPTH);

  bptl_pkg::qentry_t                 slot_r [bptl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]                  wr_ptr_r, rd_ptr_r;
  logic [bptl_pkg::QCNT_W-1:0]       count_r;

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  assign head        = slot_r[rd_ptr_r];
  assign qstat.count = count_r;
  assign qstat.full  = (count_r == bptl_pkg::QCNT_W'(bptl_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);

endmodule

`default_nettype wire

### rtl/core/bptl_back.sv
// ----------------------------------------------------------------------------
// bptl_back
// Carries out queued items: grid writes into four parity banks, sample
// reads with bilinear blend, and saturated forward differences.
// ----------------------------------------------------------------------------
`default_nettype none

module bptl_back #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  bptl_pkg::cfg_t         cfg,
  input  bptl_pkg::qentry_t      head,
  input  bptl_pkg::qstat_t       qstat,
  output logic                   pop,
  bptl_out_if.source             out_ch
);

  localparam int HR = (MAX_ROWS + 1) / 2;
  localparam int HC = (MAX_COLS + 1) / 2;
  localparam int BD = bptl_pkg::NUM_TABLES * HR * HC;
  localparam int AW = $clog2(BD);
  localparam int IW = bptl_pkg::IDX_W_MAX;

  function automatic logic [AW-1:0] bank_addr(input logic [bptl_pkg::TBL_W-1:0] tbl,
                                              input logic [IW-1:0] rh,
                                              input logic [IW-1:0] ch);
    return AW'((32'(tbl) * 32'(HR) + 32'(rh)) * 32'(HC) + 32'(ch));
  endfunction

  logic adv;
  logic phase_r;

  // issue decode
  logic                        lookup, is_deriv, blend, zero_q, wr_ok, take;
  logic [3:0]                  q;
  logic [bptl_pkg::TBL_W-1:0]  tbl;
  logic [bptl_pkg::POS_W-1:0]  tpos, ppos;
  logic [IW-1:0]               r, c, wr_r, wr_c;
  logic [15:0]                 xi, eta;
  logic [16:0]                 wx0, wy0;
  logic [33:0]                 w_nxt [4];
  logic [AW-1:0]               rd_addr [4];
  logic [AW-1:0]               wr_addr;
  logic [3:0]                  wr_en;
  logic                        rd_en;
  logic signed [31:0]          rd_data_r [4];

  // stage 1: weights and control alongside read data
  logic        s1_valid_r, s1_deriv_r, s1_phb_r, s1_zero_r, s1_temp_r, s1_r0_r, s1_c0_r;
  logic [32:0] s1_w_r [4];
  // stage 2: weighted corners
  logic        s2_valid_r, s2_deriv_r, s2_phb_r, s2_zero_r, s2_temp_r;
  logic signed [65:0] s2_prod_r [4];
  logic signed [65:0] prod_nxt [4];
  // stage 3: sample
  logic        s3_valid_r, s3_deriv_r, s3_phb_r, s3_temp_r;
  logic signed [67:0] sum;
  logic signed [31:0] s3_sample_r, hold_a_r;
  // stage 4: difference
  logic        s4_valid_r, s4_deriv_r, s4_temp_r, s4_neg_r;
  logic signed [32:0] diff, diff_n;
  logic [31:0] s4_mag_r;
  logic signed [31:0] s4_val_r;
  // stage 5: scaled difference
  logic        s5_valid_r, s5_deriv_r, s5_neg_r;
  logic [63:0] s5_prod_r;
  logic signed [31:0] s5_val_r;
  logic [47:0] scaled;
  logic signed [31:0] res_nxt;
  // output register
  logic        out_valid_r;
  logic signed [31:0] out_value_r;

  assign adv = !out_valid_r || out_ch.ready;

  // decode of the head item
  always_comb begin
    q        = head.item.quantity;
    lookup   = (head.item.command == bptl_pkg::CMD_LOOKUP);
    is_deriv = lookup && (q == bptl_pkg::QTY_DHDT || q == bptl_pkg::QTY_DHDP ||
                          q == bptl_pkg::QTY_DRHODP);
    zero_q   = lookup && (q > bptl_pkg::QTY_DRHODP);
    blend    = (q == bptl_pkg::QTY_ENTHALPY) ||
               (cfg.interp_en && (q == bptl_pkg::QTY_CP || q == bptl_pkg::QTY_DENSITY ||
                                  q == bptl_pkg::QTY_EXPANSIVITY || is_deriv));
    if (q == bptl_pkg::QTY_DRHODP)   tbl = 3'd1;
    else if (q >= bptl_pkg::QTY_DHDT) tbl = 3'd5;
    else                              tbl = q[2:0];
    tpos = (is_deriv && phase_r) ? head.t2 : head.t1;
    ppos = (is_deriv && phase_r) ? head.p2 : head.p1;
    r    = tpos[bptl_pkg::FRAC_W +: IW];
    c    = ppos[bptl_pkg::FRAC_W +: IW];
    xi   = blend ? tpos[15:0] : 16'd0;
    eta  = blend ? ppos[15:0] : 16'd0;
    wx0  = 17'h10000 - {1'b0, xi};
    wy0  = 17'h10000 - {1'b0, eta};
    // corner order: {row step, column step}
    w_nxt[0] = {17'b0, wx0} * {17'b0, wy0};
    w_nxt[1] = {17'b0, wx0} * {18'b0, eta};
    w_nxt[2] = {18'b0, xi} * {17'b0, wy0};
    w_nxt[3] = {18'b0, xi} * {18'b0, eta};
    // bank {row parity, column parity} holds its own half-row and half-column
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = bank_addr(tbl,
                             (r >> 1) + IW'(r[0] & ~b[1]),
                             (c >> 1) + IW'(c[0] & ~b[0]));
    end
    wr_r    = IW'(head.item.write_row);
    wr_c    = IW'(head.item.write_col);
    wr_ok   = (head.item.quantity < 4'(bptl_pkg::NUM_TABLES)) &&
              (32'(head.item.write_row) < 32'(MAX_ROWS)) &&
              (32'(head.item.write_col) < 32'(MAX_COLS));
    wr_addr = bank_addr(head.item.quantity[2:0], wr_r >> 1, wr_c >> 1);
    take    = adv && !qstat.empty;
    for (int b = 0; b < 4; b++) begin
      wr_en[b] = take && !lookup && wr_ok && (b[1:0] == {wr_r[0], wr_c[0]});
    end
    rd_en = take && lookup && !zero_q;
  end

  assign pop = take && (!is_deriv || phase_r);

  // grid banks
  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [31:0] mem [BD];
    always_ff @(posedge clk) begin
      if (wr_en[gb]) mem[wr_addr] <= head.item.write_value;
      if (rd_en)     rd_data_r[gb] <= mem[rd_addr[gb]];
    end
  end

  // corner products, unused corners forced to zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (s1_w_r[k] == '0) prod_nxt[k] = '0;
      else prod_nxt[k] = $signed({1'b0, s1_w_r[k]}) *
                         rd_data_r[{s1_r0_r ^ k[1], s1_c0_r ^ k[0]}];
    end
    sum = 68'(s2_prod_r[0]) + 68'(s2_prod_r[1]) + 68'(s2_prod_r[2])
        + 68'(s2_prod_r[3]) + 68'sh80000000;
    diff   = {s3_sample_r[31], s3_sample_r} - {hold_a_r[31], hold_a_r};
    diff_n = -diff;
    scaled = s5_prod_r[63:16];
    if (!s5_deriv_r)          res_nxt = s5_val_r;
    else if (!s5_neg_r)       res_nxt = (scaled > 48'h7FFFFFFF) ? 32'sh7FFFFFFF
                                                                : $signed(scaled[31:0]);
    else if (scaled >= 48'h80000000) res_nxt = 32'sh80000000;
    else                      res_nxt = $signed(32'd0 - scaled[31:0]);
  end

  // sequencer phase and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (take && is_deriv) phase_r <= !phase_r;
      s1_valid_r  <= take && lookup;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r && !(s3_deriv_r && !s3_phb_r);
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_deriv_r <= is_deriv;
      s1_phb_r   <= phase_r;
      s1_zero_r  <= zero_q;
      s1_temp_r  <= (q == bptl_pkg::QTY_DHDT);
      s1_r0_r    <= r[0];
      s1_c0_r    <= c[0];
      for (int k = 0; k < 4; k++) s1_w_r[k] <= zero_q ? 33'd0 : w_nxt[k][32:0];

      s2_deriv_r <= s1_deriv_r;
      s2_phb_r   <= s1_phb_r;
      s2_zero_r  <= s1_zero_r;
      s2_temp_r  <= s1_temp_r;
      for (int k = 0; k < 4; k++) s2_prod_r[k] <= prod_nxt[k];

      s3_deriv_r  <= s2_deriv_r;
      s3_phb_r    <= s2_phb_r;
      s3_temp_r   <= s2_temp_r;
      s3_sample_r <= s2_zero_r ? 32'sd0 : sum[63:32];

      if (s3_valid_r && s3_deriv_r && !s3_phb_r) hold_a_r <= s3_sample_r;
      s4_deriv_r <= s3_deriv_r;
      s4_temp_r  <= s3_temp_r;
      s4_neg_r   <= diff[32];
      s4_mag_r   <= diff[32] ? diff_n[31:0] : diff[31:0];
      s4_val_r   <= s3_sample_r;

      s5_deriv_r <= s4_deriv_r;
      s5_neg_r   <= s4_neg_r;
      s5_val_r   <= s4_val_r;
      s5_prod_r  <= {32'b0, s4_mag_r} *
                    {32'b0, (s4_temp_r ? cfg.temp_inv : cfg.press_inv)};

      out_value_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;

endmodule

`default_nettype wire

### rtl/core/bilinear_property_table_lookup_core.sv
// ----------------------------------------------------------------------------
// bilinear_property_table_lookup_core
// Six property grids over temperature rows and pressure columns with
// clamped bilinear lookup and saturated forward differences, Q16.16.
// A lookup result passes the front stages, the queue, the back stages and the
// output register. Throughput: writes and plain lookups one item a cycle
// unless the output stalls; a derivative lookup reads its two samples in turn,
// as the four parity banks serve four reads a cycle, and pops after both.
// Reset: control and configuration set to defaults at once; grid contents stay
// undefined until written, so there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_property_table_lookup_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  bptl_in_if.sink                             in_ch,
  bptl_out_if.source                          out_ch,
  input  wire                                 cfg_we,
  input  wire  [bptl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [bptl_pkg::DATA_W-1:0]         cfg_data
);

  bptl_pkg::cfg_t     cfg_r;
  bptl_pkg::qentry_t  push_data, head;
  bptl_pkg::qstat_t   qstat;
  logic               push, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_origin  <= '0;
      cfg_r.temp_inv     <= 32'h0001_0000;
      cfg_r.temp_rows    <= 7'd64;
      cfg_r.press_origin <= '0;
      cfg_r.press_inv    <= 32'h0001_0000;
      cfg_r.press_cols   <= 7'd64;
      cfg_r.interp_en    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bptl_pkg::REG_TEMP_ORIGIN:  cfg_r.temp_origin  <= $signed(cfg_data);
        bptl_pkg::REG_TEMP_INV:     cfg_r.temp_inv     <= cfg_data;
        bptl_pkg::REG_TEMP_ROWS:    cfg_r.temp_rows    <= cfg_data[6:0];
        bptl_pkg::REG_PRESS_ORIGIN: cfg_r.press_origin <= $signed(cfg_data);
        bptl_pkg::REG_PRESS_INV:    cfg_r.press_inv    <= cfg_data;
        bptl_pkg::REG_PRESS_COLS:   cfg_r.press_cols   <= cfg_data[6:0];
        bptl_pkg::REG_INTERP_EN:    cfg_r.interp_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bptl_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg(cfg_r), .qstat(qstat),
    .push(push), .push_data(push_data)
  );

  bptl_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .head(head), .qstat(qstat)
  );

  bptl_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head(head), .qstat(qstat),
    .pop(pop), .out_ch(out_ch)
  );

  // queue never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !push) else $error("queue push while full");

  // queue never read when empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> !pop) else $error("queue pop while empty");

  // fill count stays within depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= bptl_pkg::QCNT_W'(bptl_pkg::QUEUE_DEPTH)) else $error("queue count");

  // no result right after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("result valid after reset");

endmodule

`default_nettype wire
